[rtl/core/interface_forcing_stencil_unit_defines.svh]
// ============================================================================
// Interface forcing stencil - assertion macros
// Shared concurrent assertion forms used by the stencil RTL.
// ============================================================================
`ifndef INTERFACE_FORCING_STENCIL_UNIT_DEFINES_SVH
`define INTERFACE_FORCING_STENCIL_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFS_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ifs_pkg.sv]
// ============================================================================
// ifs_pkg - interface forcing stencil package
// Widths, types, register indexes and the stencil coefficient table.
// ============================================================================
`default_nettype none

package ifs_pkg;

   localparam int unsigned NUM_TAPS    = 6;
   localparam int unsigned NUM_SIDE    = 3;
   localparam int unsigned SAMPLE_W    = 24;
   localparam int unsigned FORCE_W     = 32;
   localparam int unsigned GAIN_W      = 32;
   localparam int unsigned GAIN_HALF_W = GAIN_W / 2;
   localparam int unsigned FRAC_W      = 24;
   localparam int unsigned COEF_W      = 10;
   // A row sum is bounded by 598 * 2^23, which needs 34 signed bits.
   localparam int unsigned SUM_W       = 34;
   // Partial product: row sum times one zero-extended gain half.
   localparam int unsigned PP_W        = SUM_W + GAIN_HALF_W + 1;
   localparam int unsigned FULL_W      = PP_W + GAIN_HALF_W;
   localparam int unsigned SHIFT_W     = FULL_W - FRAC_W;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_FORCE_GAIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NEAR_SELF  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FAR_SELF   = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0100_0000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [FORCE_W-1:0]  force_type;
   typedef logic        [GAIN_W-1:0]   gain_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   localparam force_type FORCE_MAX = 32'sh7FFF_FFFF;
   localparam force_type FORCE_MIN = 32'sh8000_0000;

   // Load strobes for the two lane pipeline stages.
   typedef struct packed {
      logic load_s1;
      logic load_s2;
   } pipe_ctl_type;

   // Rows: near_force0..2, far_force0..2.
   // Columns: near_p0 near_p1 near_p2 far_p0 far_p1 far_p2.
   localparam coef_type STENCIL [NUM_TAPS][NUM_TAPS] = '{
      '{ 10'sd0,    10'sd0,   -10'sd2,    10'sd2,    10'sd0,    10'sd0 },
      '{ 10'sd0,   -10'sd2,    10'sd27,  -10'sd27,   10'sd2,    10'sd0 },
      '{-10'sd2,    10'sd27,  -10'sd270,  10'sd270, -10'sd27,   10'sd2 },
      '{ 10'sd2,   -10'sd27,   10'sd270, -10'sd270,  10'sd27,  -10'sd2 },
      '{ 10'sd0,    10'sd2,   -10'sd27,   10'sd27,  -10'sd2,    10'sd0 },
      '{ 10'sd0,    10'sd0,    10'sd2,   -10'sd2,    10'sd0,    10'sd0 }
   };

endpackage

`default_nettype wire

[rtl/core/ifs_req_if.sv]
// ============================================================================
// ifs_req_if - sample item channel
// Valid/ready channel carrying the six pressure samples of one interface line.
// ============================================================================
`default_nettype none

interface ifs_req_if;
   logic                 valid;
   logic                 ready;
   ifs_pkg::sample_type  near_p0;
   ifs_pkg::sample_type  near_p1;
   ifs_pkg::sample_type  near_p2;
   ifs_pkg::sample_type  far_p0;
   ifs_pkg::sample_type  far_p1;
   ifs_pkg::sample_type  far_p2;

   modport source (
      output valid, near_p0, near_p1, near_p2, far_p0, far_p1, far_p2,
      input  ready
   );

   modport sink (
      input  valid, near_p0, near_p1, near_p2, far_p0, far_p1, far_p2,
      output ready
   );
endinterface

`default_nettype wire

[rtl/core/ifs_rsp_if.sv]
// ============================================================================
// ifs_rsp_if - forcing item channel
// Valid/ready channel carrying the six saturated forcing values.
// ============================================================================
`default_nettype none

interface ifs_rsp_if;
   logic                valid;
   logic                ready;
   ifs_pkg::force_type  near_force0;
   ifs_pkg::force_type  near_force1;
   ifs_pkg::force_type  near_force2;
   ifs_pkg::force_type  far_force0;
   ifs_pkg::force_type  far_force1;
   ifs_pkg::force_type  far_force2;

   modport source (
      output valid, near_force0, near_force1, near_force2,
             far_force0, far_force1, far_force2,
      input  ready
   );

   modport sink (
      input  valid, near_force0, near_force1, near_force2,
             far_force0, far_force1, far_force2,
      output ready
   );
endinterface

`default_nettype wire

[rtl/core/ifs_lane.sv]
// ============================================================================
// ifs_lane - one stencil row
// Row sum with self-term select, split gain multiply, shift and saturation.
// ============================================================================
`default_nettype none

module ifs_lane #(
   parameter int unsigned ROW = 0
) (
   input  wire logic                  clock,
   input  wire ifs_pkg::sample_type   samples [ifs_pkg::NUM_TAPS],
   input  wire logic                  self_en,
   input  wire ifs_pkg::gain_type     gain,
   input  wire ifs_pkg::pipe_ctl_type ctl,
   output ifs_pkg::force_type         lane_force
);

   typedef logic signed [ifs_pkg::PP_W-1:0]   pp_type;
   typedef logic signed [ifs_pkg::FULL_W-1:0] full_type;

   localparam bit OWN_IS_NEAR = (ROW < ifs_pkg::NUM_SIDE);

   ifs_pkg::sum_type near_sum;
   ifs_pkg::sum_type far_sum;
   ifs_pkg::sum_type own_sum;
   ifs_pkg::sum_type other_sum;
   ifs_pkg::sum_type sum_in;
   ifs_pkg::sum_type sum_ff;

   pp_type sum_ext;
   pp_type gain_hi_ext;
   pp_type gain_lo_ext;
   pp_type hi_in;
   pp_type lo_in;
   pp_type hi_ff;
   pp_type lo_ff;

   full_type                         full_prod;
   logic [ifs_pkg::SHIFT_W-1:0]      shifted;
   logic [ifs_pkg::SHIFT_W-ifs_pkg::FORCE_W:0] upper;
   logic                             fits;

   // Stage 1: constant-coefficient products, summed per side.
   always_comb begin
      near_sum = '0;
      far_sum  = '0;
      for (int i = 0; i < ifs_pkg::NUM_SIDE; i++) begin
         near_sum = near_sum + ifs_pkg::sum_type'(samples[i])
                             * ifs_pkg::sum_type'(ifs_pkg::STENCIL[ROW][i]);
         far_sum  = far_sum
                  + ifs_pkg::sum_type'(samples[i + ifs_pkg::NUM_SIDE])
                  * ifs_pkg::sum_type'(ifs_pkg::STENCIL[ROW][i + ifs_pkg::NUM_SIDE]);
      end
   end

   assign own_sum   = OWN_IS_NEAR ? near_sum : far_sum;
   assign other_sum = OWN_IS_NEAR ? far_sum  : near_sum;
   assign sum_in    = other_sum + (self_en ? own_sum : '0);

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         sum_ff <= sum_in;
      end
   end

   // Stage 2: the unsigned gain is split into halves so that each
   // multiplier stays narrow.
   assign sum_ext     = pp_type'(sum_ff);
   assign gain_hi_ext = pp_type'({1'b0, gain[ifs_pkg::GAIN_W-1:ifs_pkg::GAIN_HALF_W]});
   assign gain_lo_ext = pp_type'({1'b0, gain[ifs_pkg::GAIN_HALF_W-1:0]});
   assign hi_in       = sum_ext * gain_hi_ext;
   assign lo_in       = sum_ext * gain_lo_ext;

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   // Recombine, take the floor of the Q8.24 product and clamp to 32 bits.
   assign full_prod = (full_type'(hi_ff) <<< ifs_pkg::GAIN_HALF_W) + full_type'(lo_ff);
   assign shifted   = full_prod[ifs_pkg::FULL_W-1:ifs_pkg::FRAC_W];
   assign upper     = shifted[ifs_pkg::SHIFT_W-1:ifs_pkg::FORCE_W-1];
   assign fits      = (&upper) | ~(|upper);

   always_comb begin
      if (fits) begin
         lane_force = ifs_pkg::force_type'(shifted[ifs_pkg::FORCE_W-1:0]);
      end else if (shifted[ifs_pkg::SHIFT_W-1]) begin
         lane_force = ifs_pkg::FORCE_MIN;
      end else begin
         lane_force = ifs_pkg::FORCE_MAX;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ifs_merge.sv]
// ============================================================================
// ifs_merge - result merge and output register
// Gathers the six lane results into one item and holds it for the sink.
// ============================================================================
`default_nettype none

module ifs_merge (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire ifs_pkg::force_type  lane_force [ifs_pkg::NUM_TAPS],
   output logic                     out_ready,
   ifs_rsp_if.source                rsp_chan
);

   logic               valid_in;
   logic               valid_ff;
   ifs_pkg::force_type force_ff [ifs_pkg::NUM_TAPS];

   assign out_ready = !valid_ff || rsp_chan.ready;
   assign valid_in  = out_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && in_valid) begin
         force_ff <= lane_force;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.near_force0 = force_ff[0];
   assign rsp_chan.near_force1 = force_ff[1];
   assign rsp_chan.near_force2 = force_ff[2];
   assign rsp_chan.far_force0  = force_ff[3];
   assign rsp_chan.far_force1  = force_ff[4];
   assign rsp_chan.far_force2  = force_ff[5];

endmodule

`default_nettype wire

[rtl/core/interface_forcing_stencil_unit.sv]
// ============================================================================
// interface_forcing_stencil_unit - sixth-order interface forcing stencil
// Applies the fixed 6x6 stencil to the samples straddling a partition edge,
// scales each row by an unsigned Q8.24 gain and saturates to 32 bits.
// ============================================================================
//
//   Channel    Direction  Payload
//   ---------  ---------  ------------------------------------------------
//   req_chan   in         near_p0..2, far_p0..2 (24-bit signed samples)
//   rsp_chan   out        near_force0..2, far_force0..2 (32-bit signed)
//   csr_*      in         write enable, 2-bit index, 32-bit data
//
// One item is accepted per cycle while req_chan.ready is high, and each item yields one result item.
// Each item passes through the lane row sum register, the split gain multiply
// register, then the merge register that drives rsp_chan.
// Reset (synchronous, active high) empties the pipeline and sets the gain to
// 1.0 with both self-term flags cleared.
// Each stage holds its item only while the stage after it is full and
// stalled, so a stalled sink fills the pipeline before req_chan.ready drops.
// ============================================================================
`default_nettype none

`include "interface_forcing_stencil_unit_defines.svh"

module interface_forcing_stencil_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ifs_req_if.sink                                req_chan,
   ifs_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [ifs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ifs_pkg::GAIN_W-1:0]        csr_wr_data
);

   // ------------------------------------------------------------------
   // Configuration registers; the lanes read them with no shadow copies.
   // Users must write them only while idle; the block won't enforce it.
   // ------------------------------------------------------------------
   ifs_pkg::gain_type gain_in;
   ifs_pkg::gain_type gain_ff;
   logic              near_self_in;
   logic              near_self_ff;
   logic              far_self_in;
   logic              far_self_ff;

   always_comb begin
      gain_in      = gain_ff;
      near_self_in = near_self_ff;
      far_self_in  = far_self_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ifs_pkg::REG_FORCE_GAIN: gain_in      = csr_wr_data;
            ifs_pkg::REG_NEAR_SELF:  near_self_in = csr_wr_data[0];
            ifs_pkg::REG_FAR_SELF:   far_self_in  = csr_wr_data[0];
            default: begin
               // Unused index: the write has no effect.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= ifs_pkg::GAIN_RESET;
         near_self_ff <= 1'b0;
         far_self_ff  <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         near_self_ff <= near_self_in;
         far_self_ff  <= far_self_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline occupancy. Every stage may load when it is empty or when the
   // stage after it is loading, which lets bubbles close up under stall.
   // ------------------------------------------------------------------
   logic                  s1_valid_in;
   logic                  s1_valid_ff;
   logic                  s2_valid_in;
   logic                  s2_valid_ff;
   logic                  s1_ready;
   logic                  s2_ready;
   logic                  out_ready;
   ifs_pkg::pipe_ctl_type ctl;

   assign s2_ready    = !s2_valid_ff || out_ready;
   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   assign ctl.load_s1 = req_chan.valid && s1_ready;
   assign ctl.load_s2 = s1_valid_ff && s2_ready;

   assign s1_valid_in = s1_ready ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff    : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Six lanes, one per output row. Rows 0..2 treat the near side as their
   // own side, rows 3..5 the far side.
   // ------------------------------------------------------------------
   ifs_pkg::sample_type samples    [ifs_pkg::NUM_TAPS];
   ifs_pkg::force_type  lane_force [ifs_pkg::NUM_TAPS];

   assign samples[0] = req_chan.near_p0;
   assign samples[1] = req_chan.near_p1;
   assign samples[2] = req_chan.near_p2;
   assign samples[3] = req_chan.far_p0;
   assign samples[4] = req_chan.far_p1;
   assign samples[5] = req_chan.far_p2;

   for (genvar r = 0; r < ifs_pkg::NUM_TAPS; r++) begin : g_lane
      ifs_lane #(
         .ROW (r)
      ) u_lane (
         .clock      (clock),
         .samples    (samples),
         .self_en    ((r < ifs_pkg::NUM_SIDE) ? near_self_ff : far_self_ff),
         .gain       (gain_ff),
         .ctl        (ctl),
         .lane_force (lane_force[r])
      );
   end

   // ------------------------------------------------------------------
   // Merge the lane results into the output item register.
   // ------------------------------------------------------------------
   ifs_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid_ff),
      .lane_force (lane_force),
      .out_ready  (out_ready),
      .rsp_chan   (rsp_chan)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `IFS_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_chan.valid && req_chan.ready, s1_valid_ff, "accepted item did not reach the first stage")
   `IFS_ASSERT_SAME(a_backpressure_full, clock, reset, !req_chan.ready, s1_valid_ff && s2_valid_ff && rsp_chan.valid, "input stalled with a pipeline stage empty")
   `IFS_ASSERT_NEXT(a_s2_drains_to_out, clock, reset, s2_valid_ff && !rsp_chan.valid, rsp_chan.valid, "second stage item did not move into the empty output register")

endmodule

`default_nettype wire
